/* hw/rtl/lhpm_pkg.sv */
package lhpm_pkg;

    // histogram shape and counter width
    localparam int BUCKETS     = 8;
    localparam int COUNT_BITS  = 48;
    localparam int BKT_BITS    = $clog2(BUCKETS);
    localparam int CUM_BITS    = COUNT_BITS + BKT_BITS;

    // fixed field and register widths
    localparam int NUM_BOUNDS  = 7;
    localparam int BOUND_BITS  = 32;
    localparam int FIELD_BITS  = 32;
    localparam int MIN_BITS    = 16;
    localparam int OUT_BITS    = 48;
    localparam int DATA_BITS   = 32;
    localparam int ADDR_BITS   = 5;
    localparam int REG_BITS    = ADDR_BITS - 2;

    // percentile arithmetic
    localparam int PCT_DIV     = 100;
    localparam int MOD_BITS    = $clog2(PCT_DIV);

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [CUM_BITS-1:0]   t_cum;
    typedef logic [OUT_BITS-1:0]   t_out;

    // event codes on the mode field
    localparam logic [1:0] MODE_FLUSH  = 2'd0;
    localparam logic [1:0] MODE_ROTATE = 2'd1;
    localparam logic [1:0] MODE_ERROR  = 2'd2;

    typedef enum logic [1:0] {
        EV_FLUSH,
        EV_ROTATE,
        EV_ERROR,
        EV_NONE
    } t_kind;

    // register map, word index
    localparam logic [REG_BITS-1:0] REG_BOUND_0     = 3'd0;
    localparam logic [REG_BITS-1:0] REG_BOUND_1     = 3'd1;
    localparam logic [REG_BITS-1:0] REG_BOUND_2     = 3'd2;
    localparam logic [REG_BITS-1:0] REG_BOUND_3     = 3'd3;
    localparam logic [REG_BITS-1:0] REG_BOUND_4     = 3'd4;
    localparam logic [REG_BITS-1:0] REG_BOUND_5     = 3'd5;
    localparam logic [REG_BITS-1:0] REG_BOUND_6     = 3'd6;
    localparam logic [REG_BITS-1:0] REG_MIN_SAMPLES = 3'd7;

    localparam logic [NUM_BOUNDS-1:0][BOUND_BITS-1:0] BOUND_RESET = {
        32'd10000, 32'd5000, 32'd2500, 32'd1000, 32'd500, 32'd250, 32'd100
    };
    localparam logic [MIN_BITS-1:0] MIN_SAMPLES_RESET = 16'd100;

    typedef struct packed {
        logic [NUM_BOUNDS-1:0][BOUND_BITS-1:0] bound;
        logic [MIN_BITS-1:0]                   min_samples;
    } t_cfg;

    // one classified request
    typedef struct packed {
        t_kind                 kind;
        logic [FIELD_BITS-1:0] records;
        logic [FIELD_BITS-1:0] bytes;
        logic                  synced;
        logic [BKT_BITS-1:0]   bucket;
    } t_cmd;

    // queue status seen by its producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* hw/rtl/lhpm_front.sv */
module lhpm_front (
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_mode,
    input  logic [lhpm_pkg::FIELD_BITS-1:0] i_batch_records,
    input  logic [lhpm_pkg::FIELD_BITS-1:0] i_batch_bytes,
    input  logic [lhpm_pkg::FIELD_BITS-1:0] i_duration_us,
    input  logic                           i_synced,
    input  lhpm_pkg::t_cfg                 i_cfg,
    input  lhpm_pkg::t_qstat               i_qstat,
    output logic                           o_push,
    output lhpm_pkg::t_cmd                 o_cmd
);
    import lhpm_pkg::*;

    t_kind               kind;
    logic [BKT_BITS-1:0] bucket;
    logic                found;

    // take a request whenever the queue has room
    assign o_ready = !i_qstat.full;
    assign o_push  = i_valid && !i_qstat.full;

    // event kind decode
    always_comb begin
        unique case (i_mode)
            MODE_FLUSH:  kind = EV_FLUSH;
            MODE_ROTATE: kind = EV_ROTATE;
            MODE_ERROR:  kind = EV_ERROR;
            default:     kind = EV_NONE;
        endcase
    end

    // first bound not exceeded wins, otherwise overflow bucket
    always_comb begin
        bucket = BKT_BITS'(BUCKETS - 1);
        found  = 1'b0;
        for (int i = 0; i < BUCKETS - 1; i++) begin
            if (!found && (i_duration_us <= i_cfg.bound[i])) begin
                found  = 1'b1;
                bucket = BKT_BITS'(i);
            end
        end
    end

    // classified request
    always_comb begin
        o_cmd.kind    = kind;
        o_cmd.records = i_batch_records;
        o_cmd.bytes   = i_batch_bytes;
        o_cmd.synced  = i_synced;
        o_cmd.bucket  = bucket;
    end

endmodule

/* hw/rtl/lhpm_queue.sv */
module lhpm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lhpm_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output lhpm_pkg::t_cmd   o_head,
    output lhpm_pkg::t_qstat o_qstat
);
    import lhpm_pkg::*;

    localparam logic [QPTR_BITS-1:0] PTR_LAST = QPTR_BITS'(QUEUE_DEPTH - 1);

    t_cmd                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] n_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QPTR_BITS-1:0] n_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QCNT_BITS-1:0] n_count;

    assign o_qstat.full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rd_ptr];

    // pointer and fill tracking
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + QPTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + QPTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hw/rtl/lhpm_back.sv */
module lhpm_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lhpm_pkg::t_qstat                i_qstat,
    input  lhpm_pkg::t_cmd                  i_head,
    output logic                            o_pop,
    input  lhpm_pkg::t_cfg                  i_cfg,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_records_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_bytes_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_sync_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_rotation_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_error_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_observation_total,
    output logic [lhpm_pkg::BOUND_BITS-1:0] o_p99_latency,
    output logic                            o_p99_overflow
);
    import lhpm_pkg::*;

    localparam int SUM_BITS = ((COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS) + 1;
    localparam t_cnt COUNT_MAX = '1;
    localparam t_out OUT_MAX   = '1;
    localparam logic [MOD_BITS-1:0] MOD_LAST = MOD_BITS'(PCT_DIV - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EVAL = 2'b10
    } t_state;

    function automatic t_cnt sat_add(input t_cnt acc, input logic [FIELD_BITS-1:0] v);
        logic [SUM_BITS-1:0] s;
        s = SUM_BITS'(acc) + SUM_BITS'(v);
        return (s > SUM_BITS'(COUNT_MAX)) ? COUNT_MAX : COUNT_BITS'(s);
    endfunction

    function automatic t_cnt sat_inc(input t_cnt acc);
        return (acc == COUNT_MAX) ? acc : acc + t_cnt'(1);
    endfunction

    function automatic t_out clamp_out(input t_cnt v);
        return (v > t_cnt'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(v);
    endfunction

    t_state r_state;
    t_state n_state;

    t_cnt r_bkt_cnt [BUCKETS];
    t_cnt n_bkt_cnt [BUCKETS];
    t_cum r_cum     [BUCKETS];
    t_cum n_cum     [BUCKETS];
    t_cnt r_obs, n_obs;
    t_cnt r_rec, n_rec;
    t_cnt r_byt, n_byt;
    t_cnt r_syn, n_syn;
    t_cnt r_rot, n_rot;
    t_cnt r_err, n_err;
    t_cnt r_thr, n_thr;
    logic [MOD_BITS-1:0] r_mod, n_mod;

    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out                  r_o_rec, r_o_byt, r_o_syn, r_o_rot, r_o_err, r_o_obs;
    logic [BOUND_BITS-1:0] r_o_p99;
    logic                  r_o_ovf;

    logic                  found;
    logic [BOUND_BITS-1:0] p99;
    logic                  ovf;
    logic                  eval;

    // one request at a time: pop, then evaluate into the output register
    assign o_pop = (r_state == ST_IDLE) && !i_qstat.empty && (!r_out_valid || i_ready);
    assign eval  = (r_state == ST_EVAL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (o_pop) n_state = ST_EVAL;
            ST_EVAL: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // counter updates for the popped request
    always_comb begin
        n_bkt_cnt = r_bkt_cnt;
        n_cum     = r_cum;
        n_obs     = r_obs;
        n_rec     = r_rec;
        n_byt     = r_byt;
        n_syn     = r_syn;
        n_rot     = r_rot;
        n_err     = r_err;
        n_thr     = r_thr;
        n_mod     = r_mod;
        if (o_pop) begin
            case (i_head.kind)
                EV_FLUSH: begin
                    n_rec = sat_add(r_rec, i_head.records);
                    n_byt = sat_add(r_byt, i_head.bytes);
                    if (i_head.synced) begin
                        n_syn = sat_inc(r_syn);
                    end
                    // bucket and running prefix sums move together
                    if (r_bkt_cnt[i_head.bucket] != COUNT_MAX) begin
                        n_bkt_cnt[i_head.bucket] = r_bkt_cnt[i_head.bucket] + t_cnt'(1);
                        for (int i = 0; i < BUCKETS; i++) begin
                            if (BKT_BITS'(i) >= i_head.bucket) begin
                                n_cum[i] = r_cum[i] + t_cum'(1);
                            end
                        end
                    end
                    // threshold floor(n*99/100) grows except when n was a multiple of 100
                    if (r_obs != COUNT_MAX) begin
                        n_obs = r_obs + t_cnt'(1);
                        if (r_mod != '0) begin
                            n_thr = r_thr + t_cnt'(1);
                        end
                        n_mod = (r_mod == MOD_LAST) ? '0 : r_mod + MOD_BITS'(1);
                    end
                end
                EV_ROTATE: n_rot = sat_inc(r_rot);
                EV_ERROR:  n_err = sat_inc(r_err);
                default:   ;
            endcase
        end
    end

    // p99 bucket search over the prefix sums
    always_comb begin
        found = 1'b0;
        p99   = '0;
        ovf   = 1'b0;
        for (int i = 0; i < BUCKETS - 1; i++) begin
            if (!found && (r_cum[i] >= CUM_BITS'(r_thr))) begin
                found = 1'b1;
                p99   = i_cfg.bound[i];
            end
        end
        if (!found) begin
            ovf = 1'b1;
        end
        if (r_obs < t_cnt'(i_cfg.min_samples)) begin
            p99 = '0;
            ovf = 1'b0;
        end
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (eval) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_obs       <= '0;
            r_rec       <= '0;
            r_byt       <= '0;
            r_syn       <= '0;
            r_rot       <= '0;
            r_err       <= '0;
            r_thr       <= '0;
            r_mod       <= '0;
            for (int i = 0; i < BUCKETS; i++) begin
                r_bkt_cnt[i] <= '0;
                r_cum[i]     <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_obs       <= n_obs;
            r_rec       <= n_rec;
            r_byt       <= n_byt;
            r_syn       <= n_syn;
            r_rot       <= n_rot;
            r_err       <= n_err;
            r_thr       <= n_thr;
            r_mod       <= n_mod;
            r_bkt_cnt   <= n_bkt_cnt;
            r_cum       <= n_cum;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (eval) begin
            r_o_rec <= clamp_out(r_rec);
            r_o_byt <= clamp_out(r_byt);
            r_o_syn <= clamp_out(r_syn);
            r_o_rot <= clamp_out(r_rot);
            r_o_err <= clamp_out(r_err);
            r_o_obs <= clamp_out(r_obs);
            r_o_p99 <= p99;
            r_o_ovf <= ovf;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_records_total     = r_o_rec;
    assign o_bytes_total       = r_o_byt;
    assign o_sync_total        = r_o_syn;
    assign o_rotation_total    = r_o_rot;
    assign o_error_total       = r_o_err;
    assign o_observation_total = r_o_obs;
    assign o_p99_latency       = r_o_p99;
    assign o_p99_overflow      = r_o_ovf;

endmodule

/* hw/rtl/latency_histogram_p99_monitor.sv */
// Flush latency histogram with a running p99 estimate. Each request (flush,
// segment rotation, io error or an unused mode) yields one result with all
// saturating totals and the bound of the first bucket whose cumulative count
// reaches floor(observations*99/100); the estimate is 0 below min_samples,
// and the overflow flag marks the unbounded bucket. A front stage classifies
// the request and picks its bucket, a two-entry queue decouples it from the
// back unit, which takes one request at a time: an idle state pops it and
// updates the counters and the running prefix sums, an evaluate state
// searches the buckets into the output register. The back unit pops the next
// request only once its output register is free or being taken; the queue
// keeps accepting requests while it has room. Counters are ready right after
// reset. Bound and min_samples registers sit at byte addresses 0x00..0x1c and
// may only be written while the block is idle.
module latency_histogram_p99_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [1:0]                      i_mode,
    input  logic [lhpm_pkg::FIELD_BITS-1:0] i_batch_records,
    input  logic [lhpm_pkg::FIELD_BITS-1:0] i_batch_bytes,
    input  logic [lhpm_pkg::FIELD_BITS-1:0] i_duration_us,
    input  logic                            i_synced,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_records_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_bytes_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_sync_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_rotation_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_error_total,
    output logic [lhpm_pkg::OUT_BITS-1:0]   o_observation_total,
    output logic [lhpm_pkg::BOUND_BITS-1:0] o_p99_latency,
    output logic                            o_p99_overflow,
    // register port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lhpm_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [lhpm_pkg::DATA_BITS-1:0]  pwdata,
    output logic [lhpm_pkg::DATA_BITS-1:0]  prdata,
    output logic                            pready
);
    import lhpm_pkg::*;

    t_cfg               r_cfg;
    t_cfg               n_cfg;
    logic [REG_BITS-1:0] reg_idx;
    logic               wr_en;

    t_cmd   push_cmd;
    t_cmd   head_cmd;
    t_qstat qstat;
    logic   push;
    logic   pop;

    // register write and read
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_BOUND_0:     n_cfg.bound[0]    = pwdata;
                REG_BOUND_1:     n_cfg.bound[1]    = pwdata;
                REG_BOUND_2:     n_cfg.bound[2]    = pwdata;
                REG_BOUND_3:     n_cfg.bound[3]    = pwdata;
                REG_BOUND_4:     n_cfg.bound[4]    = pwdata;
                REG_BOUND_5:     n_cfg.bound[5]    = pwdata;
                REG_BOUND_6:     n_cfg.bound[6]    = pwdata;
                REG_MIN_SAMPLES: n_cfg.min_samples = pwdata[MIN_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BOUND_0:     prdata = r_cfg.bound[0];
            REG_BOUND_1:     prdata = r_cfg.bound[1];
            REG_BOUND_2:     prdata = r_cfg.bound[2];
            REG_BOUND_3:     prdata = r_cfg.bound[3];
            REG_BOUND_4:     prdata = r_cfg.bound[4];
            REG_BOUND_5:     prdata = r_cfg.bound[5];
            REG_BOUND_6:     prdata = r_cfg.bound[6];
            REG_MIN_SAMPLES: prdata = DATA_BITS'(r_cfg.min_samples);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bound       <= BOUND_RESET;
            r_cfg.min_samples <= MIN_SAMPLES_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // classify and enqueue
    lhpm_front u_front (
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_batch_records (i_batch_records),
        .i_batch_bytes   (i_batch_bytes),
        .i_duration_us   (i_duration_us),
        .i_synced        (i_synced),
        .i_cfg           (r_cfg),
        .i_qstat         (qstat),
        .o_push          (push),
        .o_cmd           (push_cmd)
    );

    lhpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_qstat (qstat)
    );

    // counters and p99 evaluation
    lhpm_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_qstat             (qstat),
        .i_head              (head_cmd),
        .o_pop               (pop),
        .i_cfg               (r_cfg),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_records_total     (o_records_total),
        .o_bytes_total       (o_bytes_total),
        .o_sync_total        (o_sync_total),
        .o_rotation_total    (o_rotation_total),
        .o_error_total       (o_error_total),
        .o_observation_total (o_observation_total),
        .o_p99_latency       (o_p99_latency),
        .o_p99_overflow      (o_p99_overflow)
    );

endmodule

/* hw/rtl/lhpm_checker.sv */
module lhpm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_valid,
    input logic                            i_ready,
    input logic [lhpm_pkg::OUT_BITS-1:0]   o_records_total,
    input logic [lhpm_pkg::OUT_BITS-1:0]   o_sync_total,
    input logic [lhpm_pkg::OUT_BITS-1:0]   o_observation_total,
    input logic [lhpm_pkg::BOUND_BITS-1:0] o_p99_latency,
    input logic                            o_p99_overflow,
    input logic                            psel,
    input logic                            pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_p99_latency)
            && $stable(o_observation_total) && $stable(o_records_total))
        else $error("result changed while stalled");

    // back unit needs an evaluate cycle after each taken result
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("result shown without evaluate cycle");

    // overflow bucket never carries a bound
    a_ovf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_p99_overflow |-> o_p99_latency == '0)
        else $error("overflow with nonzero latency");

    // synced flushes are a subset of observed flushes
    a_sync_le_obs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sync_total <= o_observation_total)
        else $error("sync total above observation total");

    // register port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("pready low");

endmodule

bind latency_histogram_p99_monitor lhpm_checker u_lhpm_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    import lhpm_pkg::*;

    localparam int PCT_RANK = 99;
    localparam logic [63:0] COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
    localparam logic [63:0] OUT_MAX = (64'd1 << OUT_BITS) - 1;

    // expected totals of one result
    typedef struct {
        logic [OUT_BITS-1:0]   record_sum;
        logic [OUT_BITS-1:0]   byte_sum;
        logic [OUT_BITS-1:0]   sync_sum;
        logic [OUT_BITS-1:0]   rotation_sum;
        logic [OUT_BITS-1:0]   error_sum;
        logic [OUT_BITS-1:0]   observation_sum;
        logic [BOUND_BITS-1:0] p99_latency;
        logic                  p99_overflow;
    } t_monitor_totals;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [1:0]            i_mode = EV_FLUSH;
    logic [FIELD_BITS-1:0] i_batch_records = '0;
    logic [FIELD_BITS-1:0] i_batch_bytes = '0;
    logic [FIELD_BITS-1:0] i_duration_us = '0;
    logic                  i_synced = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [OUT_BITS-1:0]   o_records_total;
    logic [OUT_BITS-1:0]   o_bytes_total;
    logic [OUT_BITS-1:0]   o_sync_total;
    logic [OUT_BITS-1:0]   o_rotation_total;
    logic [OUT_BITS-1:0]   o_error_total;
    logic [OUT_BITS-1:0]   o_observation_total;
    logic [BOUND_BITS-1:0] o_p99_latency;
    logic                  o_p99_overflow;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_BITS-1:0]  paddr = '0;
    logic [DATA_BITS-1:0]  pwdata = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;

    // traffic shaping
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_hold = 1'b0;
    int   mismatch_count = 0;

    // histogram mirror and register mirror
    logic [63:0]           bucket_hits [BUCKETS];
    logic [63:0]           obs_cnt = '0;
    logic [63:0]           rec_cnt = '0;
    logic [63:0]           byte_cnt = '0;
    logic [63:0]           sync_cnt = '0;
    logic [63:0]           rot_cnt = '0;
    logic [63:0]           err_cnt = '0;
    logic [BOUND_BITS-1:0] bound_cfg [NUM_BOUNDS];
    logic [MIN_BITS-1:0]   min_samples_cfg = MIN_SAMPLES_RESET;

    t_monitor_totals pending_totals [$];

    latency_histogram_p99_monitor i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_mode              (i_mode),
        .i_batch_records     (i_batch_records),
        .i_batch_bytes       (i_batch_bytes),
        .i_duration_us       (i_duration_us),
        .i_synced            (i_synced),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_records_total     (o_records_total),
        .o_bytes_total       (o_bytes_total),
        .o_sync_total        (o_sync_total),
        .o_rotation_total    (o_rotation_total),
        .o_error_total       (o_error_total),
        .o_observation_total (o_observation_total),
        .o_p99_latency       (o_p99_latency),
        .o_p99_overflow      (o_p99_overflow),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < BUCKETS; i++) bucket_hits[i] = '0;
        for (int i = 0; i < NUM_BOUNDS; i++) bound_cfg[i] = BOUND_RESET[i];
    end

    function automatic logic [63:0] sat_add(input logic [63:0] acc, input logic [63:0] v);
        if (v > COUNT_MAX - acc) return COUNT_MAX;
        return acc + v;
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(input logic [63:0] v);
        return (v > OUT_MAX) ? OUT_MAX[OUT_BITS-1:0] : v[OUT_BITS-1:0];
    endfunction

    // update the histogram mirror for one request and queue its totals
    task automatic predict_totals(input logic [1:0] mode, input logic [FIELD_BITS-1:0] records,
                                  input logic [FIELD_BITS-1:0] nbytes,
                                  input logic [FIELD_BITS-1:0] dur, input logic synced);
        t_monitor_totals t;
        int              bkt;
        int              hit;
        logic [63:0]     thr;
        logic [63:0]     cum;
        bkt = BUCKETS - 1;
        hit = BUCKETS;
        cum = '0;
        case (t_kind'(mode))
            EV_FLUSH: begin
                // priority search over the bounds
                for (int i = BUCKETS - 2; i >= 0; i--) begin
                    if (dur <= bound_cfg[i]) bkt = i;
                end
                rec_cnt = sat_add(rec_cnt, 64'(records));
                byte_cnt = sat_add(byte_cnt, 64'(nbytes));
                if (synced) sync_cnt = sat_add(sync_cnt, 64'd1);
                bucket_hits[bkt] = sat_add(bucket_hits[bkt], 64'd1);
                obs_cnt = sat_add(obs_cnt, 64'd1);
            end
            EV_ROTATE: rot_cnt = sat_add(rot_cnt, 64'd1);
            EV_ERROR:  err_cnt = sat_add(err_cnt, 64'd1);
            default: ;
        endcase
        t.p99_latency = '0;
        t.p99_overflow = 1'b0;
        if (obs_cnt >= 64'(min_samples_cfg)) begin
            thr = (obs_cnt / PCT_DIV) * PCT_RANK + ((obs_cnt % PCT_DIV) * PCT_RANK) / PCT_DIV;
            for (int i = 0; i < BUCKETS; i++) begin
                if (hit == BUCKETS) begin
                    cum = (bucket_hits[i] > ~cum) ? '1 : cum + bucket_hits[i];
                    if (cum >= thr) hit = i;
                end
            end
            if (hit < BUCKETS - 1) t.p99_latency = bound_cfg[hit];
            else t.p99_overflow = 1'b1;
        end
        t.record_sum = clamp_out(rec_cnt);
        t.byte_sum = clamp_out(byte_cnt);
        t.sync_sum = clamp_out(sync_cnt);
        t.rotation_sum = clamp_out(rot_cnt);
        t.error_sum = clamp_out(err_cnt);
        t.observation_sum = clamp_out(obs_cnt);
        pending_totals.push_back(t);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
        if (act !== exp) begin
            $error("%s: expected %0h, got %0h", name, exp, act);
            mismatch_count++;
        end
    endtask

    // request side monitor feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            predict_totals(i_mode, i_batch_records, i_batch_bytes, i_duration_us, i_synced);
        end
    end

    // result side checker
    always @(posedge i_clk) begin
        t_monitor_totals t;
        if (i_rst_n && o_valid === 1'b1 && i_ready) begin
            if (pending_totals.size() == 0) begin
                $error("result with no request pending");
                mismatch_count++;
            end else begin
                t = pending_totals.pop_front();
                check_field("records_total", t.record_sum, o_records_total);
                check_field("bytes_total", t.byte_sum, o_bytes_total);
                check_field("sync_total", t.sync_sum, o_sync_total);
                check_field("rotation_total", t.rotation_sum, o_rotation_total);
                check_field("error_total", t.error_sum, o_error_total);
                check_field("observation_total", t.observation_sum, o_observation_total);
                check_field("p99_latency", t.p99_latency, o_p99_latency);
                check_field("p99_overflow", t.p99_overflow, o_p99_overflow);
            end
        end
    end

    // receiver with random stalls and a long hold on request
    always @(posedge i_clk) begin
        i_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // send one request; returns at the edge that accepts it
    task automatic send_request(input logic [1:0] mode, input logic [FIELD_BITS-1:0] records,
                                input logic [FIELD_BITS-1:0] nbytes,
                                input logic [FIELD_BITS-1:0] dur, input logic synced);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= mode;
        i_batch_records <= records;
        i_batch_bytes <= nbytes;
        i_duration_us <= dur;
        i_synced <= synced;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // stop sending and wait until every result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_totals.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // register write followed by a read back
    task automatic program_register(input logic [REG_BITS-1:0] idx,
                                    input logic [DATA_BITS-1:0] value);
        logic [DATA_BITS-1:0] exp;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_MIN_SAMPLES) min_samples_cfg = value[MIN_BITS-1:0];
        else bound_cfg[idx] = value;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        exp = (idx == REG_MIN_SAMPLES) ? DATA_BITS'(min_samples_cfg) : bound_cfg[idx];
        check_field("prdata", 64'(exp), 64'(prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_profile(input logic [NUM_BOUNDS-1:0][BOUND_BITS-1:0] bounds,
                                   input logic [MIN_BITS-1:0] min_samples);
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            program_register(REG_BOUND_0 + REG_BITS'(i), bounds[i]);
        end
        program_register(REG_MIN_SAMPLES, DATA_BITS'(min_samples));
    endtask

    // latencies cluster around the bounds, with some spread and some wide values
    function automatic logic [FIELD_BITS-1:0] random_duration();
        int pick;
        pick = $urandom_range(9);
        if (pick < 6)
            return bound_cfg[$urandom_range(NUM_BOUNDS - 1)] + FIELD_BITS'($urandom_range(2)) - 1;
        if (pick < 8) return $urandom_range(20000);
        return $urandom;
    endfunction

    task automatic random_request();
        int                    pick;
        logic [1:0]            mode;
        logic [FIELD_BITS-1:0] records;
        pick = $urandom_range(99);
        if (pick < 70) mode = EV_FLUSH;
        else if (pick < 82) mode = EV_ROTATE;
        else if (pick < 94) mode = EV_ERROR;
        else mode = EV_NONE;
        records = $urandom_range(1) ? $urandom : $urandom_range(4096);
        send_request(mode, records, $urandom, random_duration(), 1'($urandom));
    endtask

    // minimum of zero with nothing observed reports the first bound
    task automatic test_zero_threshold();
        program_register(REG_MIN_SAMPLES, '0);
        send_request(EV_ROTATE, '0, '0, '0, 1'b0);
        send_request(EV_ERROR, '1, '1, '1, 1'b1);
        send_request(EV_NONE, '1, '1, '1, 1'b1);
        drain_results();
        program_register(REG_MIN_SAMPLES, 32'd5);
    endtask

    // every event kind, extreme field values, ignored fields
    task automatic test_event_kinds();
        send_request(EV_FLUSH, '1, '1, '0, 1'b1);
        send_request(EV_FLUSH, '0, '0, '1, 1'b0);
        send_request(EV_ROTATE, '1, '1, '1, 1'b1);
        send_request(EV_ERROR, 32'h5555_5555, 32'haaaa_aaaa, 32'd7, 1'b1);
        send_request(EV_NONE, '1, '1, '0, 1'b1);
        send_request(EV_FLUSH, 32'haaaa_aaaa, 32'h5555_5555, 32'd150, 1'b1);
    endtask

    // latencies on and just past every bound
    task automatic test_bucket_edges();
        for (int i = 0; i < NUM_BOUNDS; i++) begin
            send_request(EV_FLUSH, 32'd1, 32'd64, bound_cfg[i], 1'(i));
            send_request(EV_FLUSH, 32'd2, 32'd128, bound_cfg[i] + 1, 1'(i + 1));
        end
        send_request(EV_FLUSH, 32'd3, 32'd256, '0, 1'b0);
        send_request(EV_FLUSH, 32'd4, 32'd512, '1, 1'b1);
        drain_results();
    endtask

    task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) random_request();
        drain_results();
    endtask

    // long receiver hold while the sender keeps offering requests
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (300) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
            repeat (40) random_request();
        join
        drain_results();
    endtask

    // test sequence
    initial begin
        logic [NUM_BOUNDS-1:0][BOUND_BITS-1:0] bounds;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_idle_pct = 17;
        rx_idle_pct = 54;
        test_zero_threshold();
        test_event_kinds();
        test_bucket_edges();

        // ascending random bounds
        bounds[0] = $urandom_range(500);
        for (int i = 1; i < NUM_BOUNDS; i++) bounds[i] = bounds[i-1] + $urandom_range(1, 3000);
        program_profile(bounds, 16'd20);
        test_random_traffic(130, 17, 54);

        // descending bounds exercise the priority search
        for (int i = 0; i < NUM_BOUNDS; i++) bounds[i] = 20000 - i * 2500 - $urandom_range(200);
        program_profile(bounds, 16'd0);
        test_random_traffic(130, 54, 17);

        // extreme bounds
        bounds = '0;
        bounds[NUM_BOUNDS-1] = '1;
        program_profile(bounds, 16'd1);
        test_random_traffic(100, 0, 0);
        bounds = '1;
        program_profile(bounds, '1);
        test_random_traffic(40, 0, 0);

        program_profile(BOUND_RESET, 16'd50);
        test_backpressure();

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/lhpm_pkg.sv
hw/rtl/lhpm_front.sv
hw/rtl/lhpm_queue.sv
hw/rtl/lhpm_back.sv
hw/rtl/latency_histogram_p99_monitor.sv
hw/rtl/lhpm_checker.sv
tb/tb.sv
